[design/ptgrq_pkg.sv]
// shared types, sizes and status codes for the per-track grouped request queue
// no dependencies; every other file of the block imports this package
package ptgrq_pkg;

	// table sizes
	localparam int MAX_TRACKS  = 16;
	localparam int QUEUE_DEPTH = 16;

	// derived widths
	localparam int SLOT_W    = $clog2(MAX_TRACKS);
	localparam int USED_W    = $clog2(MAX_TRACKS + 1);
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_DEPTH = MAX_TRACKS * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(TAG_DEPTH);

	// field widths
	localparam int TRACK_W = 16;
	localparam int TAG_W   = 16;
	localparam int PEND_W  = 9;
	localparam int STAT_W  = 2;

	// action codes
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ADDED  = 2'd0;
	localparam logic [STAT_W-1:0] ST_SERVED = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	// update request into the slot table
	typedef struct packed {
		logic               add_en;
		logic               take_en;
		logic               new_slot;
		logic [SLOT_W-1:0]  slot;
		logic [TRACK_W-1:0] track;
	} slot_cmd_t;

	// search results out of the slot table
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  hit_slot;
		logic               hit_full;
		logic [PTR_W-1:0]   hit_wr_ptr;
		logic               table_full;
		logic [SLOT_W-1:0]  next_free;
		logic               any_ready;
		logic [SLOT_W-1:0]  ready_slot;
		logic [PTR_W-1:0]   ready_rd_ptr;
		logic [TRACK_W-1:0] ready_track;
		logic [USED_W-1:0]  used;
	} slot_stat_t;

	// flat tag memory address of one queue entry
	function automatic logic [ADDR_W-1:0] tag_addr(logic [SLOT_W-1:0] slot,
		logic [PTR_W-1:0] ptr);
		tag_addr = ADDR_W'(slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
	endfunction

	// queue pointer advance with wrap
	function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

[design/per_track_grouped_request_queue.sv]
// Per-track grouped request queue, top level.
//
// Input words on the s_axis channel: tuser is the action (add or take),
// tdata carries the track number and the request tag. Every input word
// yields exactly one result word on the m_axis channel: tuser is the
// status (added, served, nothing to serve, full and dropped), tdata holds
// the served tag, the served track and the count of requests still waiting.
//
// An add stores the tag in the queue of its track; a track claims the next
// slot when first seen and keeps it for good. A take serves the oldest tag
// of the lowest slot that has work.
//
// Each word passes a search state, with slot search plus tag memory access,
// then a result state, with result load once the output register is free.
// The tag memory read is registered; a new word is accepted only once the
// last one has loaded its result.
// The result sits in an output register; a stalled receiver holds it and the
// block keeps accepting and working until the next result has to be loaded.
// Reset clears fill levels, pointers, counters and handshake state at once; the
// tag memory needs no clearing, entries are read only after being written.
module per_track_grouped_request_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // track_number[15:0], request_tag[31:16]
	input  logic        s_axis_tuser,   // action[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // served_tag[15:0], served_track[31:16],
	                                    // pending_count[40:32], zero[47:41]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);
	import ptgrq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_FIND = 2'd1;
	localparam logic [1:0] S_RES  = 2'd2;

	logic [1:0]         state_q;
	logic               action_q;
	logic [TRACK_W-1:0] track_q;
	logic [TAG_W-1:0]   tag_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [TRACK_W-1:0] res_track_q;
	logic [PEND_W-1:0]  waiting_q;

	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [TRACK_W-1:0] out_track_q;
	logic [PEND_W-1:0]  out_pend_q;

	slot_cmd_t          cmd;
	slot_stat_t         stat;
	logic               add_full;
	logic [SLOT_W-1:0]  add_slot;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [TAG_W-1:0]   ram_rdata;
	logic               in_acc;
	logic               load;

	assign s_axis_tready = state_q == S_IDLE;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load          = (state_q == S_RES) && (!out_valid_q || m_axis_tready);

	// slot choice and memory access during the search cycle
	always_comb begin
		add_full      = stat.hit ? stat.hit_full : stat.table_full;
		add_slot      = stat.hit ? stat.hit_slot : stat.next_free;
		cmd.add_en    = (state_q == S_FIND) && (action_q == ACT_ADD) && !add_full;
		cmd.take_en   = (state_q == S_FIND) && (action_q == ACT_TAKE) && stat.any_ready;
		cmd.new_slot  = !stat.hit;
		cmd.slot      = (action_q == ACT_ADD) ? add_slot : stat.ready_slot;
		cmd.track     = track_q;
		ram_we        = cmd.add_en;
		ram_waddr     = tag_addr(add_slot, stat.hit ? stat.hit_wr_ptr : '0);
		ram_re        = cmd.take_en;
		ram_raddr     = tag_addr(stat.ready_slot, stat.ready_rd_ptr);
	end

	ptgrq_slot_table u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	ptgrq_tag_ram u_tags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tag_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// captured input word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q <= s_axis_tuser;
			track_q  <= s_axis_tdata[15:0];
			tag_q    <= s_axis_tdata[31:16];
		end
	end

	// outcome of the search cycle
	always_ff @(posedge clk) begin
		if (state_q == S_FIND) begin
			res_track_q <= stat.ready_track;
			if (action_q == ACT_ADD) begin
				res_status_q <= add_full ? ST_FULL : ST_ADDED;
			end else begin
				res_status_q <= stat.any_ready ? ST_SERVED : ST_EMPTY;
			end
		end
	end

	// sequencer and waiting count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			waiting_q <= '0;
		end else begin
			if (cmd.add_en) begin
				waiting_q <= waiting_q + PEND_W'(1);
			end else if (cmd.take_en && waiting_q != '0) begin
				waiting_q <= waiting_q - PEND_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= res_status_q;
			out_pend_q   <= waiting_q;
			if (res_status_q == ST_SERVED) begin
				out_tag_q   <= ram_rdata;
				out_track_q <= res_track_q;
			end else begin
				out_tag_q   <= '0;
				out_track_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {7'd0, out_pend_q, out_track_q, out_tag_q};

`ifndef SYNTH
	// a serve takes one request off the waiting count
	a_take_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_en && waiting_q != '0) |=> waiting_q == $past(waiting_q) - PEND_W'(1))
		else $error("waiting count not decremented on serve");

	// a stalled result is never overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES && out_valid_q && !m_axis_tready) |=> state_q == S_RES)
		else $error("result loaded over a stalled word");

	// slot count stays within the table
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.used <= USED_W'(MAX_TRACKS))
		else $error("slot count beyond table size");
`endif

endmodule

[design/ptgrq_tag_ram.sv]
// tag memory: one queue of request tags per slot, laid out slot by slot
// one write port, one read port with registered data; uses ptgrq_pkg
module ptgrq_tag_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ptgrq_pkg::ADDR_W-1:0]  waddr,
	input  logic [ptgrq_pkg::TAG_W-1:0]   wdata,
	input  logic                          re,
	input  logic [ptgrq_pkg::ADDR_W-1:0]  raddr,
	output logic [ptgrq_pkg::TAG_W-1:0]   rdata
);
	import ptgrq_pkg::*;

	logic [TAG_W-1:0] mem [TAG_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered data, holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/ptgrq_slot_table.sv]
// slot table: owning track, fill level and queue pointers of each slot
// track match and first non-empty slot search; uses ptgrq_pkg
module ptgrq_slot_table (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptgrq_pkg::slot_cmd_t   cmd,
	output ptgrq_pkg::slot_stat_t  stat
);
	import ptgrq_pkg::*;

	logic [TRACK_W-1:0] track_q [MAX_TRACKS];
	logic [FILL_W-1:0]  fill_q  [MAX_TRACKS];
	logic [PTR_W-1:0]   rd_q    [MAX_TRACKS];
	logic [PTR_W-1:0]   wr_q    [MAX_TRACKS];
	logic [USED_W-1:0]  used_q;

	// lowest taken slot owning the track, lowest taken slot with work
	always_comb begin
		stat = '0;
		for (int s = MAX_TRACKS - 1; s >= 0; s--) begin
			if (USED_W'(s) < used_q) begin
				if (track_q[s] == cmd.track) begin
					stat.hit      = 1'b1;
					stat.hit_slot = SLOT_W'(s);
				end
				if (fill_q[s] != '0) begin
					stat.any_ready  = 1'b1;
					stat.ready_slot = SLOT_W'(s);
				end
			end
		end
		stat.hit_full     = fill_q[stat.hit_slot] == FILL_W'(QUEUE_DEPTH);
		stat.hit_wr_ptr   = wr_q[stat.hit_slot];
		stat.ready_rd_ptr = rd_q[stat.ready_slot];
		stat.ready_track  = track_q[stat.ready_slot];
		stat.table_full   = used_q == USED_W'(MAX_TRACKS);
		stat.next_free    = used_q[SLOT_W-1:0];
		stat.used         = used_q;
	end

	// owning track, written once when a slot is claimed
	always_ff @(posedge clk) begin
		if (cmd.add_en && cmd.new_slot) begin
			track_q[cmd.slot] <= cmd.track;
		end
	end

	// fill levels, pointers and slot count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int s = 0; s < MAX_TRACKS; s++) begin
				fill_q[s] <= '0;
				rd_q[s]   <= '0;
				wr_q[s]   <= '0;
			end
		end else if (cmd.add_en) begin
			fill_q[cmd.slot] <= fill_q[cmd.slot] + FILL_W'(1);
			wr_q[cmd.slot]   <= next_ptr(wr_q[cmd.slot]);
			if (cmd.new_slot) begin
				used_q <= used_q + USED_W'(1);
			end
		end else if (cmd.take_en) begin
			fill_q[cmd.slot] <= fill_q[cmd.slot] - FILL_W'(1);
			rd_q[cmd.slot]   <= next_ptr(rd_q[cmd.slot]);
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the per-track grouped request queue
// depends on ptgrq_pkg and per_track_grouped_request_queue from the design folder
module tb;
	import ptgrq_pkg::*;

	localparam int POOL_SIZE   = MAX_TRACKS + 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 12;

	// one request word as the sender sees it
	typedef struct {
		logic               action;
		logic [TRACK_W-1:0] track;
		logic [TAG_W-1:0]   tag;
		bit                 hold;
	} sched_req_t;

	// one result word as the receiver should see it
	typedef struct {
		logic [STAT_W-1:0]  status;
		logic [TAG_W-1:0]   tag;
		logic [TRACK_W-1:0] track;
		logic [PEND_W-1:0]  pending;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // track_number[15:0], request_tag[31:16]
	logic        s_axis_tuser = 1'b0; // action[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // served_tag[15:0], served_track[31:16],
	                                  // pending_count[40:32], zero[47:41]
	logic [1:0]  m_axis_tuser;        // status[1:0]

	sched_req_t    request_q[$];
	sched_result_t outcome_q[$];
	int unsigned   words_sent = 0;
	int unsigned   words_checked = 0;
	int unsigned   mismatches = 0;
	int unsigned   cycles = 0;
	int unsigned   random_items = 0;
	bit            hold_next = 1'b0;
	logic [TRACK_W-1:0] track_pool[POOL_SIZE];

	int tx_gap = 0;
	int tx_calm = 0;
	int rx_hold = 0;
	int rx_calm = 0;

	// scheduler state mirrored by the bench
	logic [TRACK_W-1:0] owner_track[MAX_TRACKS];
	int                 slots_taken = 0;
	int                 queued[MAX_TRACKS];
	int                 rd_at[MAX_TRACKS];
	int                 wr_at[MAX_TRACKS];
	logic [TAG_W-1:0]   held_tags[MAX_TRACKS][QUEUE_DEPTH];
	int                 waiting = 0;

	per_track_grouped_request_queue u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// queue or serve one request and return the word the block should answer with
	function automatic sched_result_t schedule_outcome(sched_req_t r);
		sched_result_t res;
		int s;
		int hit;
		res.status = ST_ADDED;
		res.tag    = '0;
		res.track  = '0;
		hit = -1;
		if (r.action == ACT_ADD) begin
			for (s = 0; s < slots_taken; s++)
				if (hit < 0 && owner_track[s] == r.track) hit = s;
			if (hit < 0 && slots_taken == MAX_TRACKS) begin
				res.status = ST_FULL;
			end else begin
				// first sighting of a track claims the next slot for good
				if (hit < 0) begin
					hit = slots_taken;
					owner_track[hit] = r.track;
					queued[hit] = 0;
					rd_at[hit] = 0;
					wr_at[hit] = 0;
					slots_taken++;
				end
				if (queued[hit] == QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					held_tags[hit][wr_at[hit]] = r.tag;
					wr_at[hit] = (wr_at[hit] + 1) % QUEUE_DEPTH;
					queued[hit]++;
					waiting++;
				end
			end
		end else begin
			// lowest slot with work wins
			for (s = 0; s < slots_taken; s++)
				if (hit < 0 && queued[s] != 0) hit = s;
			if (hit < 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.status = ST_SERVED;
				res.tag    = held_tags[hit][rd_at[hit]];
				res.track  = owner_track[hit];
				rd_at[hit] = (rd_at[hit] + 1) % QUEUE_DEPTH;
				queued[hit]--;
				waiting--;
			end
		end
		res.pending = PEND_W'(waiting);
		return res;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic queue_word(input logic action, input logic [TRACK_W-1:0] track,
		input logic [TAG_W-1:0] tag);
		sched_req_t r;
		r.action = action;
		r.track  = track;
		r.tag    = tag;
		r.hold   = hold_next;
		hold_next = 1'b0;
		request_q.push_back(r);
	endtask

	task automatic queue_add(input logic [TRACK_W-1:0] track);
		queue_word(ACT_ADD, track, TAG_W'($urandom));
		random_items++;
	endtask

	task automatic queue_take();
		queue_word(ACT_TAKE, TRACK_W'($urandom), TAG_W'($urandom));
		random_items++;
	endtask

	// one random stretch: a burst on one track, a drain, or a mix with noise
	task automatic random_phase();
		int kind;
		int n;
		int k;
		logic [TRACK_W-1:0] t;
		kind = $urandom_range(0, 9);
		if (kind < 3) begin
			t = track_pool[$urandom_range(0, POOL_SIZE - 1)];
			n = $urandom_range(4, 20);
			for (k = 0; k < n; k++) queue_add(t);
		end else if (kind < 5) begin
			n = $urandom_range(4, 30);
			for (k = 0; k < n; k++) queue_take();
		end else begin
			n = $urandom_range(10, 40);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 99) < 5)
					queue_add(TRACK_W'($urandom));
				else if ($urandom_range(0, 99) < 55)
					queue_add(track_pool[$urandom_range(0, POOL_SIZE - 1)]);
				else
					queue_take();
			end
		end
	endtask

	// sender: presents queued words with random gaps
	always @(posedge clk or negedge arst_n) begin : drive_p
		int unsigned sent_now;
		sched_req_t cur;
		sched_req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			sent_now = words_sent;
			if (s_axis_tvalid && s_axis_tready) begin
				cur.action = s_axis_tuser;
				cur.track  = s_axis_tdata[15:0];
				cur.tag    = s_axis_tdata[31:16];
				cur.hold   = 1'b0;
				outcome_q.push_back(schedule_outcome(cur));
				sent_now = sent_now + 1;
				words_sent <= sent_now;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (request_q.size() != 0 &&
					(!request_q[0].hold || sent_now == words_checked)) begin
					nxt = request_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {nxt.tag, nxt.track};
					s_axis_tuser  <= nxt.action;
					if (tx_calm != 0) begin
						tx_calm <= tx_calm - 1;
						tx_gap <= 0;
					end else begin
						tx_gap <= idle_len();
						if ($urandom_range(0, 49) == 0) tx_calm <= $urandom_range(20, 60);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string what, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// receiver: random stalls and a field-by-field check of every result word
	always @(posedge clk or negedge arst_n) begin : check_p
		sched_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_checked <= words_checked + 1;
				if (outcome_q.size() == 0) begin
					$display("%0t: result word with nothing expected, expected none, actual %h %h",
						$time, m_axis_tuser, m_axis_tdata);
					mismatches++;
				end else begin
					want = outcome_q.pop_front();
					compare_field("status", 16'(want.status), 16'(m_axis_tuser));
					compare_field("served_tag", want.tag, m_axis_tdata[15:0]);
					compare_field("served_track", want.track, m_axis_tdata[31:16]);
					compare_field("pending_count", 16'(want.pending), 16'(m_axis_tdata[40:32]));
				end
			end
			if (rx_hold != 0) begin
				rx_hold <= rx_hold - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (rx_calm != 0)
					rx_calm <= rx_calm - 1;
				else if ($urandom_range(0, 99) < 2)
					rx_calm <= $urandom_range(30, 90);
				else if ($urandom_range(0, 3) == 0)
					rx_hold <= idle_len();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int i;
		int j;
		bit dup;
		logic [TRACK_W-1:0] cand;

		// directed: empty take with junk fields, extreme tracks and tags,
		// slot order over arrival order, a drained slot keeping its priority
		queue_word(ACT_TAKE, 16'hFFFF, 16'hFFFF);
		queue_word(ACT_ADD, 16'h0000, 16'h0000);
		queue_word(ACT_ADD, 16'hFFFF, 16'hFFFF);
		queue_word(ACT_ADD, 16'h0000, TAG_W'($urandom));
		queue_word(ACT_TAKE, 16'h0000, 16'h0000);
		queue_word(ACT_TAKE, 16'h0000, 16'h0000);
		queue_word(ACT_TAKE, 16'h0000, 16'h0000);
		queue_word(ACT_TAKE, 16'h0000, 16'h0000);
		queue_word(ACT_ADD, 16'hFFFF, TAG_W'($urandom));
		queue_word(ACT_ADD, 16'h0000, TAG_W'($urandom));
		queue_word(ACT_TAKE, 16'h5A5A, 16'hA5A5);
		queue_word(ACT_TAKE, 16'h0000, 16'h0000);
		queue_word(ACT_TAKE, TRACK_W'($urandom), TAG_W'($urandom));

		// distinct tracks: the first MAX_TRACKS own slots, the rest are turned away
		track_pool[0] = 16'h0000;
		track_pool[1] = 16'hFFFF;
		for (i = 2; i < POOL_SIZE; i++) begin
			do begin
				cand = TRACK_W'($urandom);
				dup = 1'b0;
				for (j = 0; j < i; j++)
					if (track_pool[j] == cand) dup = 1'b1;
			end while (dup);
			track_pool[i] = cand;
		end

		// claim the slot table in pool order once the directed words are done
		hold_next = 1'b1;
		for (i = 0; i < POOL_SIZE; i++) queue_add(track_pool[i]);
		while (random_items < 520) random_phase();

		// fill every queue to the brim, overflow, then drain past empty
		hold_next = 1'b1;
		for (i = 0; i < MAX_TRACKS; i++)
			for (j = 0; j < QUEUE_DEPTH; j++) queue_add(track_pool[i]);
		queue_add(track_pool[0]);
		queue_add(track_pool[MAX_TRACKS + 1]);
		for (i = 0; i < MAX_TRACKS * QUEUE_DEPTH + 2; i++) queue_take();

		while (random_items < 1050) random_phase();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last word to go out and every answer to come back
		while (request_q.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
